### sv/pcpt_pkg.sv
// Shared constants and types for the parametric curve point and tangent unit.
package pcpt_pkg;

   localparam int ANG_FRAC  = 30;
   localparam int TABLE_LEN = 30;
   localparam int POS_Z_W   = 48;
   localparam int CSR_IDX_W = 8;
   localparam int TRIG_W    = 34;
   localparam int ANG_W     = 33;

   localparam logic [32:0] TWO_PI_Q30   = 33'd6746518852;
   localparam logic [32:0] PI_Q30       = 33'd3373259426;
   localparam logic [32:0] HALF_PI_Q30  = 33'd1686629713;
   localparam logic [29:0] GAIN_Q30     = 30'd652032874;
   localparam logic [29:0] INV_2PI_Q32  = 30'd683565276;

   localparam logic [1:0] KIND_CIRCLE  = 2'd0;
   localparam logic [1:0] KIND_ELLIPSE = 2'd1;
   localparam logic [1:0] KIND_HELIX   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CURVE_KIND = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_A     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_B     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH      = 8'd3;

   localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
      30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
      30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
      30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
      30'd31,        30'd15,        30'd8,         30'd4,         30'd2
   };

   typedef struct packed {
      logic [1:0]         curve_kind;
      logic signed [31:0] axis_a;
      logic signed [31:0] axis_b;
      logic signed [31:0] pitch;
   } cfg_type;

endpackage

### sv/pcpt_req_if.sv
// Input channel: one curve parameter per beat.
interface pcpt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] curve_param;
   modport source (output valid, output curve_param, input ready);
   modport sink (input valid, input curve_param, output ready);
endinterface

### sv/pcpt_rsp_if.sv
// Result channel: point and tangent per beat.
interface pcpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [47:0] pos_z;
   logic signed [31:0] slope_x;
   logic signed [31:0] slope_y;
   logic signed [31:0] slope_z;
   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output slope_x, output slope_y, output slope_z, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input slope_x, input slope_y, input slope_z, output ready);
endinterface

### sv/pcpt_csr_if.sv
// Configuration write channel.
interface pcpt_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### sv/pcpt_range.sv
// Angle range reduction: reciprocal-multiply modulo 2*pi, wrap and quadrant fold.
module pcpt_range #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [31:0]                  t,
   output logic signed [pcpt_pkg::ANG_W-1:0]   r_out,
   output logic                                flip_out
);
   localparam int S     = 30 - FRAC_BITS;
   localparam int MAG_W = 32 + S;
   localparam logic [63:0] RECIP = (64'd1 << (32 + S)) / 64'(pcpt_pkg::TWO_PI_Q30);
   localparam logic [33:0] TWO_PI_U  = {1'b0, pcpt_pkg::TWO_PI_Q30};
   localparam logic signed [33:0] TWO_PI_S  = $signed({1'b0, pcpt_pkg::TWO_PI_Q30});
   localparam logic signed [33:0] PI_S      = $signed({1'b0, pcpt_pkg::PI_Q30});
   localparam logic signed [33:0] HALF_PI_S = $signed({1'b0, pcpt_pkg::HALF_PI_Q30});

   logic [31:0]      tmag_in, tmag_ff, tmag2_ff;
   logic             neg_ff1, neg_ff2, neg_ff3, neg_ff4;
   logic [S+31:0]    qk;
   logic [S-1:0]     q_ff;
   logic [MAG_W-1:0] mag;
   logic [S+32:0]    qtp;
   logic [S+32:0]    rem0_full;
   logic [33:0]      rem0_ff;
   logic [33:0]      m_in;
   logic [32:0]      m_ff;

   // quotient estimate is exact or one short; one compare-subtract fixes it
   assign tmag_in   = t[31] ? 32'(-t) : 32'(t);
   assign qk        = tmag_ff * RECIP[S-1:0];
   assign mag       = {tmag2_ff, {S{1'b0}}};
   assign qtp       = q_ff * pcpt_pkg::TWO_PI_Q30;
   assign rem0_full = {1'b0, mag} - qtp;
   assign m_in      = (rem0_ff >= TWO_PI_U) ? rem0_ff - TWO_PI_U : rem0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tmag_ff  <= tmag_in;
         neg_ff1  <= t[31];
         q_ff     <= qk[S+31:32];
         tmag2_ff <= tmag_ff;
         neg_ff2  <= neg_ff1;
         rem0_ff  <= rem0_full[33:0];
         neg_ff3  <= neg_ff2;
         m_ff     <= m_in[32:0];
         neg_ff4  <= neg_ff3;
      end
   end

   // wrap into (-pi, pi]
   logic [32:0]        r1;
   logic signed [33:0] rw_in, rw_ff;

   assign r1 = neg_ff4 ? ((m_ff == 33'd0) ? 33'd0 : pcpt_pkg::TWO_PI_Q30 - m_ff) : m_ff;
   assign rw_in = (r1 > pcpt_pkg::PI_Q30) ? $signed({1'b0, r1}) - TWO_PI_S
                                          : $signed({1'b0, r1});

   // fold into [-pi/2, pi/2]
   logic signed [33:0]                fold;
   logic                              flip_in;
   logic signed [pcpt_pkg::ANG_W-1:0] r_ff;
   logic                              flip_ff;

   always_comb begin
      fold    = rw_ff;
      flip_in = 1'b0;
      if (rw_ff > HALF_PI_S) begin
         fold    = rw_ff - PI_S;
         flip_in = 1'b1;
      end else if (rw_ff < -HALF_PI_S) begin
         fold    = rw_ff + PI_S;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rw_ff   <= rw_in;
         r_ff    <= fold[pcpt_pkg::ANG_W-1:0];
         flip_ff <= flip_in;
      end
   end

   assign r_out    = r_ff;
   assign flip_out = flip_ff;
endmodule

### sv/pcpt_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration.
module pcpt_cordic #(
   parameter int STAGES = 18
) (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [pcpt_pkg::ANG_W-1:0]    r_in,
   input  logic                                 flip_in,
   output logic signed [pcpt_pkg::TRIG_W-1:0]   x_out,
   output logic signed [pcpt_pkg::TRIG_W-1:0]   y_out,
   output logic                                 flip_out
);
   localparam int XW = pcpt_pkg::TRIG_W;
   localparam int ZW = pcpt_pkg::ANG_W;

   logic signed [XW-1:0] x_ff [STAGES];
   logic signed [XW-1:0] y_ff [STAGES];
   logic signed [ZW-1:0] z_ff [STAGES];
   logic                 flip_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ANG = $signed({3'b0, pcpt_pkg::ATAN_Q30[i]});
      logic signed [XW-1:0] xs, ys, x_in, y_in;
      logic signed [ZW-1:0] zs, z_in;
      logic                 fs;
      if (i == 0) begin : g_first
         assign xs = $signed({4'b0, pcpt_pkg::GAIN_Q30});
         assign ys = '0;
         assign zs = r_in;
         assign fs = flip_in;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
         assign fs = flip_ff[i-1];
      end
      always_comb begin
         if (!zs[ZW-1]) begin
            x_in = xs - (ys >>> i);
            y_in = ys + (xs >>> i);
            z_in = zs - ANG;
         end else begin
            x_in = xs + (ys >>> i);
            y_in = ys - (xs >>> i);
            z_in = zs + ANG;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            flip_ff[i] <= fs;
         end
      end
   end

   assign x_out    = x_ff[STAGES-1];
   assign y_out    = y_ff[STAGES-1];
   assign flip_out = flip_ff[STAGES-1];
endmodule

### sv/pcpt_scale.sv
// Quadrant sign fix, coefficient multiply, rounding and saturation.
module pcpt_scale (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [pcpt_pkg::TRIG_W-1:0] x_in,
   input  logic signed [pcpt_pkg::TRIG_W-1:0] y_in,
   input  logic                               flip_in,
   input  logic signed [31:0]                 coef_a,
   input  logic signed [31:0]                 coef_y,
   output logic signed [31:0]                 pos_x,
   output logic signed [31:0]                 pos_y,
   output logic signed [31:0]                 slope_x,
   output logic signed [31:0]                 slope_y
);
   localparam int TW = pcpt_pkg::TRIG_W;
   localparam int PW = TW + 32;
   localparam int RW = PW - pcpt_pkg::ANG_FRAC;
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (pcpt_pkg::ANG_FRAC - 1);

   function automatic logic signed [31:0] sat32(input logic signed [RW:0] v);
      logic signed [RW:0] hi_lim, lo_lim;
      hi_lim = (RW+1)'(32'sh7fffffff);
      lo_lim = -hi_lim - (RW+1)'(1);
      if (v > hi_lim) return 32'sh7fffffff;
      if (v < lo_lim) return 32'sh80000000;
      return v[31:0];
   endfunction

   logic signed [TW-1:0] sin_ff, cos_ff;
   logic signed [PW-1:0] px_ff, py_ff, sx_ff, sy_ff;
   logic signed [PW-1:0] px_r, py_r, sx_r, sy_r;
   logic signed [31:0]   px_ff2, py_ff2, sx_ff2, sy_ff2;

   assign px_r = (px_ff + HALF) >>> pcpt_pkg::ANG_FRAC;
   assign py_r = (py_ff + HALF) >>> pcpt_pkg::ANG_FRAC;
   assign sx_r = (sx_ff + HALF) >>> pcpt_pkg::ANG_FRAC;
   assign sy_r = (sy_ff + HALF) >>> pcpt_pkg::ANG_FRAC;

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= flip_in ? -y_in : y_in;
         cos_ff <= flip_in ? -x_in : x_in;
         px_ff  <= coef_a * sin_ff;
         py_ff  <= coef_y * cos_ff;
         sx_ff  <= coef_a * cos_ff;
         sy_ff  <= coef_y * sin_ff;
         px_ff2 <= sat32((RW+1)'(px_r));
         py_ff2 <= sat32((RW+1)'(py_r));
         sx_ff2 <= sat32((RW+1)'(sx_r));
         // saturate the product first, then negate and saturate again
         sy_ff2 <= sat32(-((RW+1)'(sat32((RW+1)'(sy_r)))));
      end
   end

   assign pos_x   = px_ff2;
   assign pos_y   = py_ff2;
   assign slope_x = sx_ff2;
   assign slope_y = sy_ff2;
endmodule

### sv/pcpt_helix.sv
// Helix height and rise rate: pitch*t/(2*pi) and pitch/(2*pi), delay-matched.
module pcpt_helix #(
   parameter int FRAC_BITS = 16,
   parameter int DEPTH     = 40
) (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [31:0]                   t,
   input  logic signed [31:0]                   pitch,
   input  logic                                 helix_en,
   output logic signed [pcpt_pkg::POS_Z_W-1:0]  pos_z,
   output logic signed [31:0]                   slope_z
);
   localparam int ZW    = pcpt_pkg::POS_Z_W;
   localparam int DLY   = DEPTH - 4;
   localparam logic [63:0] RND  = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] ZMAX = (64'd1 << (ZW - 1)) - 64'd1;

   logic [31:0] pm_ff, tm_ff;
   logic        zneg_ff1, pneg_ff1, zneg_ff2, pneg_ff2, zneg_ff3, pneg_ff3, zneg_ff4;
   logic [63:0] m_ff;
   logic [61:0] smp_ff, hia_ff, lop_ff;
   logic [30:0] sm_ff;
   logic [62:0] hi_ff;
   logic signed [31:0] sz_ff4;

   logic [61:0] sm_sum;
   assign sm_sum = smp_ff + 62'(64'd1 << 31);

   always_ff @(posedge clock) begin
      if (adv) begin
         pm_ff    <= pitch[31] ? 32'(-pitch) : 32'(pitch);
         tm_ff    <= t[31] ? 32'(-t) : 32'(t);
         zneg_ff1 <= pitch[31] ^ t[31];
         pneg_ff1 <= pitch[31];
         m_ff     <= 64'(pm_ff) * 64'(tm_ff);
         smp_ff   <= 62'(pm_ff) * 62'(pcpt_pkg::INV_2PI_Q32);
         zneg_ff2 <= zneg_ff1;
         pneg_ff2 <= pneg_ff1;
         hia_ff   <= 62'(m_ff[63:32]) * 62'(pcpt_pkg::INV_2PI_Q32);
         lop_ff   <= 62'(m_ff[31:0]) * 62'(pcpt_pkg::INV_2PI_Q32);
         sm_ff    <= sm_sum[61:31] >> 1;
         zneg_ff3 <= zneg_ff2;
         pneg_ff3 <= pneg_ff2;
         hi_ff    <= 63'(hia_ff) + 63'(lop_ff >> 32);
         sz_ff4   <= pneg_ff3 ? -$signed({1'b0, sm_ff}) : $signed({1'b0, sm_ff});
         zneg_ff4 <= zneg_ff3;
      end
   end

   logic [63:0]        zm;
   logic signed [ZW-1:0] z_in;
   assign zm = (64'(hi_ff) + RND) >> FRAC_BITS;

   always_comb begin
      if (zneg_ff4) begin
         z_in = (zm > ZMAX) ? {1'b1, {(ZW-1){1'b0}}} : -$signed(zm[ZW-1:0]);
      end else begin
         z_in = (zm > ZMAX) ? {1'b0, {(ZW-1){1'b1}}} : $signed(zm[ZW-1:0]);
      end
   end

   logic signed [ZW-1:0] z_ff  [DLY];
   logic signed [31:0]   sz_ff [DLY];

   for (genvar k = 0; k < DLY; k++) begin : g_dly
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv) begin
               z_ff[k]  <= z_in;
               sz_ff[k] <= sz_ff4;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (adv) begin
               z_ff[k]  <= z_ff[k-1];
               sz_ff[k] <= sz_ff[k-1];
            end
         end
      end
   end

   assign pos_z   = helix_en ? z_ff[DLY-1] : '0;
   assign slope_z = helix_en ? sz_ff[DLY-1] : '0;
endmodule

### sv/parametric_curve_point_tangent_top.sv
// Parametric curve point and tangent unit, top level.
// Takes one curve parameter t (signed radians, FRAC_BITS fraction bits) per beat and
// returns x, y, z and the analytic tangent for a circle, ellipse or helix selected by
// curve_kind. Throughput is one beat per cycle while result beats are taken. The
// pipeline is the six-stage reciprocal-multiply modulo 2*pi reduction with wrap and
// fold, the one-iteration-per-stage CORDIC and the multiply/round stages.
// The whole pipeline holds when the result beat is not taken.
// Configuration registers are to be written by the user only while the pipeline is
// empty; the block itself does not enforce this.
module parametric_curve_point_tangent_top #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic         clock,
   input  logic         reset,
   pcpt_req_if.sink     req,
   pcpt_rsp_if.source   rsp,
   pcpt_csr_if.sink     csr
);
   localparam int RANGE_LAT = 6;
   localparam int LAT       = RANGE_LAT + CORDIC_STAGES + 3;

   pcpt_pkg::cfg_type cfg_ff;
   logic [LAT-1:0]    valid_ff;
   logic              adv;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            pcpt_pkg::REG_CURVE_KIND: cfg_ff.curve_kind <= csr.data[1:0];
            pcpt_pkg::REG_AXIS_A:     cfg_ff.axis_a     <= csr.data;
            pcpt_pkg::REG_AXIS_B:     cfg_ff.axis_b     <= csr.data;
            pcpt_pkg::REG_PITCH:      cfg_ff.pitch      <= csr.data;
            default: ;
         endcase
      end
   end

   assign adv       = !valid_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req.valid};
      end
   end

   logic signed [pcpt_pkg::ANG_W-1:0]  r;
   logic                               flip_r, flip_c;
   logic signed [pcpt_pkg::TRIG_W-1:0] cx, cy;
   logic signed [31:0]                 coef_y;

   assign coef_y = (cfg_ff.curve_kind == pcpt_pkg::KIND_ELLIPSE) ? cfg_ff.axis_b
                                                                 : cfg_ff.axis_a;

   pcpt_range #(.FRAC_BITS(FRAC_BITS)) u_range (
      .clock(clock), .adv(adv), .t(req.curve_param), .r_out(r), .flip_out(flip_r)
   );

   pcpt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock(clock), .adv(adv), .r_in(r), .flip_in(flip_r),
      .x_out(cx), .y_out(cy), .flip_out(flip_c)
   );

   pcpt_scale u_scale (
      .clock(clock), .adv(adv), .x_in(cx), .y_in(cy), .flip_in(flip_c),
      .coef_a(cfg_ff.axis_a), .coef_y(coef_y),
      .pos_x(rsp.pos_x), .pos_y(rsp.pos_y), .slope_x(rsp.slope_x), .slope_y(rsp.slope_y)
   );

   pcpt_helix #(.FRAC_BITS(FRAC_BITS), .DEPTH(LAT)) u_helix (
      .clock(clock), .adv(adv), .t(req.curve_param), .pitch(cfg_ff.pitch),
      .helix_en(cfg_ff.curve_kind == pcpt_pkg::KIND_HELIX),
      .pos_z(rsp.pos_z), .slope_z(rsp.slope_z)
   );
endmodule

### tb/tb_if.sv
// Testbench package: the expected contents of one result beat.
package tb_curve_pkg;
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [47:0] pos_z;
      logic signed [31:0] slope_x;
      logic signed [31:0] slope_y;
      logic signed [31:0] slope_z;
   } curve_point_type;
endpackage

### tb/tb_top.sv
// Self-checking testbench for the parametric curve point and tangent unit.
module tb_top;
   localparam int FRAC = 16;
   localparam int STAGES = 18;
   localparam int LATENCY = 6 + STAGES + 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint ATAN_TBL [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149,
      1048575, 524287, 262143, 131071, 65535,
      32767, 16383, 8191, 4095, 2047,
      1023, 511, 255, 127, 63, 31, 15, 8, 4, 2};

   logic clock = 0;
   logic reset = 1;
   always #10 clock = ~clock;

   pcpt_req_if req ();
   pcpt_rsp_if rsp ();
   pcpt_csr_if csr ();

   parametric_curve_point_tangent_top #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink));

   logic [1:0]         kind_q;
   logic signed [31:0] axis_a_q, axis_b_q, pitch_q;

   tb_curve_pkg::curve_point_type expected_points[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;

   function automatic longint floor_shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clamp32(longint v);
      if (v < -64'sd2147483648) return -64'sd2147483648;
      if (v > 64'sd2147483647) return 64'sd2147483647;
      return v;
   endfunction

   function automatic longint scale(longint coef, longint trig);
      return clamp32(floor_shr(coef * trig + (64'sd1 <<< 29), 30));
   endfunction

   function automatic tb_curve_pkg::curve_point_type predict_point(logic signed [31:0] t_in);
      tb_curve_pkg::curve_point_type pt;
      longint t, r, x, y, dx, dy, s, c, a, ay, p, zs, szv;
      bit flip;
      logic [63:0] pm, tm, m, hi, zm, sm;
      t = t_in;
      a = axis_a_q;
      ay = (kind_q == pcpt_pkg::KIND_ELLIPSE) ? longint'(axis_b_q) : a;
      p = pitch_q;
      r = (t * (64'sd1 <<< (30 - FRAC))) % 64'sd6746518852;
      if (r < 0) r += 64'sd6746518852;
      if (r > 64'sd3373259426) r -= 64'sd6746518852;
      flip = 0;
      if (r > 64'sd1686629713) begin
         r -= 64'sd3373259426; flip = 1;
      end else if (r < -64'sd1686629713) begin
         r += 64'sd3373259426; flip = 1;
      end
      x = 652032874; y = 0;
      for (int i = 0; i < STAGES && i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (r >= 0) begin
            x -= dx; y += dy; r -= ATAN_TBL[i];
         end else begin
            x += dx; y -= dy; r += ATAN_TBL[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
      pt.pos_x = 32'(scale(a, s));
      pt.pos_y = 32'(scale(ay, c));
      pt.slope_x = 32'(scale(a, c));
      pt.slope_y = 32'(clamp32(-scale(ay, s)));
      pt.pos_z = '0;
      pt.slope_z = '0;
      if (kind_q == pcpt_pkg::KIND_HELIX) begin
         pm = (p < 0) ? -p : p;
         tm = (t < 0) ? -t : t;
         m = pm * tm;
         hi = (m >> 32) * 64'd683565276 + (((m & 64'hFFFFFFFF) * 64'd683565276) >> 32);
         zm = (hi + (64'd1 << (FRAC - 1))) >> FRAC;
         sm = (pm * 64'd683565276 + (64'd1 << 31)) >> 32;
         zs = zm;
         if ((p < 0) != (t < 0)) zs = -zs;
         if (zs > 64'sd140737488355327) zs = 64'sd140737488355327;
         if (zs < -64'sd140737488355328) zs = -64'sd140737488355328;
         pt.pos_z = 48'(zs);
         szv = (p < 0) ? -longint'(sm) : longint'(sm);
         pt.slope_z = 32'(clamp32(szv));
      end
      return pt;
   endfunction

   // valid stays high after a beat; the next call or drain() decides what follows
   task automatic send_param(logic signed [31:0] t);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.curve_param <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_points.push_back(predict_point(t));
      @(negedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] val);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (idx)
         pcpt_pkg::REG_CURVE_KIND: kind_q = val[1:0];
         pcpt_pkg::REG_AXIS_A:     axis_a_q = val;
         pcpt_pkg::REG_AXIS_B:     axis_b_q = val;
         pcpt_pkg::REG_PITCH:      pitch_q = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (expected_points.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic configure(logic [1:0] k, logic [31:0] a, logic [31:0] b, logic [31:0] p);
      drain();
      write_reg(pcpt_pkg::REG_CURVE_KIND, 32'(k));
      write_reg(pcpt_pkg::REG_AXIS_A, a);
      write_reg(pcpt_pkg::REG_AXIS_B, b);
      write_reg(pcpt_pkg::REG_PITCH, p);
      csr.valid <= 0;
   endtask

   function automatic logic [31:0] rand_param();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0007FFFF) - 32'h0003FFFF;
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom_range(1) ? 32'h80000000 + $urandom_range(7)
                                           : 32'h7FFFFFFF - $urandom_range(7);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] pts [14] = '{32'sh0, 32'sh1, -32'sh1, 32'sh7FFFFFFF,
         32'sh80000000, 32'sh0001921F, -32'sh0001921F, 32'sh0003243F, -32'sh0003243F,
         32'sh0006487F, 32'sh00064880, 32'sh0000C910, -32'sh0000C910, 32'sh00120000};
      configure(pcpt_pkg::KIND_CIRCLE, 32'h00010000, 32'h0, 32'h0);
      foreach (pts[i]) send_param(pts[i]);
      configure(pcpt_pkg::KIND_ELLIPSE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      foreach (pts[i]) if (i < 6) send_param(pts[i]);
      configure(pcpt_pkg::KIND_HELIX, 32'h80000000, 32'h00020000, 32'h80000000);
      send_param(32'sh7FFFFFFF);
      send_param(32'sh80000000);
      configure(2'd3, 32'h00030000, 32'h00050000, 32'h7FFFFFFF);
      send_param(32'sh00018000);
      drain();
      write_reg(8'd9, 32'hDEADBEEF);
      csr.valid <= 0;
      send_param(32'sh00028000);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0)
            configure(2'($urandom_range(3)), $urandom, $urandom,
                      $urandom_range(1) ? $urandom : {16'($urandom_range(3)), 16'($urandom)});
         send_param(rand_param());
      end
   endtask

   task automatic test_backpressure();
      drain();
      hold_off = 300;
      for (int i = 0; i < 80; i++) send_param(rand_param());
   endtask

   // receiver side
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp.ready <= 0;
         hold_off <= hold_off - 1;
      end else
         rsp.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      tb_curve_pkg::curve_point_type exp_pt, got;
      cycles <= cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.slope_x, rsp.slope_y, rsp.slope_z};
         if (expected_points.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %p", got);
         end else begin
            exp_pt = expected_points.pop_front();
            if (got !== exp_pt) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", exp_pt, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req.valid = 0;
      req.curve_param = 0;
      csr.valid = 0;
      csr.index = 0;
      csr.data = 0;
      rsp.ready = 0;
      kind_q = 0; axis_a_q = 0; axis_b_q = 0; pitch_q = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_param(32'sh00010000);
      test_directed();
      send_idle_pct = 19; recv_idle_pct = 47;
      test_random(500);
      send_idle_pct = 47; recv_idle_pct = 19;
      test_random(500);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(500);
      drain();
      if (errors == 0 && expected_points.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

### files.f
sv/pcpt_pkg.sv
sv/pcpt_req_if.sv
sv/pcpt_rsp_if.sv
sv/pcpt_csr_if.sv
sv/pcpt_range.sv
sv/pcpt_cordic.sv
sv/pcpt_scale.sv
sv/pcpt_helix.sv
sv/parametric_curve_point_tangent_top.sv
tb/tb_if.sv
tb/tb_top.sv
